// ----- hw/rtl/sfms_pkg.sv -----
package sfms_pkg;

   // Field and store sizes fixed by the mailbox format.
   localparam int BYTE_W      = 8;
   localparam int SIG_W       = 32;
   localparam int OUT_DEPTH   = 32;
   localparam int OUT_ADDR_W  = 5;
   localparam int POS_W       = 5;
   localparam int SIG_LENGTH  = 4;
   localparam int CSR_INDEX_W = 2;

   // Frame phases.
   localparam logic [1:0] PH_START   = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_END     = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   // Request functions.
   localparam logic [1:0] FUNC_BYTE  = 2'd0;
   localparam logic [1:0] FUNC_POLL  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_CHANGE = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_SIG = 2'd0;
   localparam logic [1:0] CSR_END_SIG   = 2'd1;
   localparam logic [1:0] CSR_OVERRUN   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic item_read;
      logic out_write;
      logic byte_commit;
      logic scan_clear;
      logic scan_read;
      logic scan_commit;
      logic scan_skip;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] phase;
      logic       scan_diff;
      logic       scan_last;
      logic       out_free;
   } sts_type;

endpackage

// ----- hw/rtl/sfms_ctrl.sv -----
module sfms_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic [1:0]       req_func,
   output logic             req_tready,
   input  sfms_pkg::sts_type sts,
   output sfms_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_BYTE     = 3'd1;
   localparam logic [2:0] ST_SCAN_RD  = 3'd2;
   localparam logic [2:0] ST_SCAN_CMP = 3'd3;
   localparam logic [2:0] ST_FINISH   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // A new request is taken only from the idle state.
   assign req_tready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_func)
                  sfms_pkg::FUNC_BYTE: begin
                     cmd.item_read = 1'b1;
                     state_in      = ST_BYTE;
                  end
                  sfms_pkg::FUNC_POLL: begin
                     if (sts.phase == sfms_pkg::PH_DONE) begin
                        cmd.scan_clear = 1'b1;
                        state_in       = ST_SCAN_RD;
                     end
                  end
                  sfms_pkg::FUNC_WRITE: begin
                     cmd.out_write = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BYTE: begin
            if (sts.out_free) begin
               cmd.byte_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // An unchanged entry moves on at once; a changed one waits for the output slot.
            if (!sts.scan_diff || sts.out_free) begin
               cmd.scan_commit = sts.scan_diff;
               cmd.scan_skip   = !sts.scan_diff;
               state_in        = sts.scan_last ? ST_FINISH : ST_SCAN_RD;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/sfms_datapath.sv -----
module sfms_datapath #(
   parameter int BUFFER_SIZE = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sfms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfms_pkg::SIG_W-1:0]        csr_wdata,
   input  logic [sfms_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic [sfms_pkg::OUT_ADDR_W-1:0]   req_out_index,
   input  logic [sfms_pkg::BYTE_W-1:0]       req_out_value,
   input  sfms_pkg::cmd_type                 cmd,
   output sfms_pkg::sts_type                 sts,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [1:0]                        rsp_kind,
   output logic                              rsp_tlast,
   output logic                              rsp_reply_valid,
   output logic [sfms_pkg::BYTE_W-1:0]       rsp_reply_byte,
   output logic [sfms_pkg::OUT_ADDR_W-1:0]   rsp_change_addr,
   output logic [sfms_pkg::BYTE_W-1:0]       rsp_old_value,
   output logic [sfms_pkg::BYTE_W-1:0]       rsp_new_value
);

   localparam int SA_W = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;

   // Configuration registers.
   logic [sfms_pkg::SIG_W-1:0]      start_sig_ff;
   logic [sfms_pkg::SIG_W-1:0]      end_sig_ff;
   logic [sfms_pkg::OUT_ADDR_W-1:0] ovr_idx_ff;

   // Frame tracking.
   logic [1:0]                phase_ff;
   logic [1:0]                phase_in;
   logic [sfms_pkg::POS_W-1:0] pos_ff;
   logic [sfms_pkg::POS_W-1:0] pos_in;
   logic [sfms_pkg::POS_W:0]   pos_inc;

   // Stores and their valid bits; an entry never written reads as zero.
   logic [sfms_pkg::BYTE_W-1:0] stage_mem [BUFFER_SIZE];
   logic [BUFFER_SIZE-1:0]      stage_vld_ff;
   logic [sfms_pkg::BYTE_W-1:0] comm_mem [BUFFER_SIZE];
   logic [BUFFER_SIZE-1:0]      comm_vld_ff;
   logic [sfms_pkg::BYTE_W-1:0] out_mem [sfms_pkg::OUT_DEPTH];
   logic [sfms_pkg::OUT_DEPTH-1:0] out_vld_ff;

   logic [sfms_pkg::BYTE_W-1:0] out_rd_ff;
   logic [sfms_pkg::BYTE_W-1:0] stage_rd_ff;
   logic [sfms_pkg::BYTE_W-1:0] comm_rd_ff;
   logic [sfms_pkg::BYTE_W-1:0] rx_ff;
   logic [SA_W-1:0]             scan_addr_ff;

   logic [sfms_pkg::OUT_ADDR_W-1:0] out_raddr;
   logic                            out_we;
   logic [sfms_pkg::OUT_ADDR_W-1:0] out_waddr;
   logic [sfms_pkg::BYTE_W-1:0]     out_wdata;
   logic [SA_W-1:0]                 stage_waddr;

   // Byte handling results.
   logic [sfms_pkg::SIG_W-1:0]  sig_sel;
   logic [sfms_pkg::BYTE_W-1:0] sig_byte;
   logic                        byte_rv;
   logic [sfms_pkg::BYTE_W-1:0] byte_reply;
   logic                        stage_we;
   logic                        out_bump;

   // Output register.
   logic                            rsp_valid_ff;
   logic [1:0]                      rsp_kind_ff;
   logic                            rsp_last_ff;
   logic                            rsp_rv_ff;
   logic [sfms_pkg::BYTE_W-1:0]     rsp_rb_ff;
   logic [sfms_pkg::OUT_ADDR_W-1:0] rsp_ca_ff;
   logic [sfms_pkg::BYTE_W-1:0]     rsp_ov_ff;
   logic [sfms_pkg::BYTE_W-1:0]     rsp_nv_ff;
   logic                            rsp_load;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_sig_ff <= '0;
         end_sig_ff   <= '0;
         ovr_idx_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sfms_pkg::CSR_START_SIG: start_sig_ff <= csr_wdata;
            sfms_pkg::CSR_END_SIG:   end_sig_ff   <= csr_wdata;
            sfms_pkg::CSR_OVERRUN:   ovr_idx_ff   <= csr_wdata[sfms_pkg::OUT_ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Byte decision: signature match, payload staging or overrun count.
   assign sig_sel  = (phase_ff == sfms_pkg::PH_END) ? end_sig_ff : start_sig_ff;
   assign sig_byte = sig_sel[{pos_ff[1:0], 3'b000} +: sfms_pkg::BYTE_W];
   assign pos_inc  = {1'b0, pos_ff} + (sfms_pkg::POS_W+1)'(1);

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      byte_rv    = 1'b0;
      byte_reply = '0;
      stage_we   = 1'b0;
      out_bump   = 1'b0;
      unique case (phase_ff) inside
         sfms_pkg::PH_START, sfms_pkg::PH_END: begin
            if (sig_byte == rx_ff) begin
               byte_rv    = 1'b1;
               byte_reply = ~sig_byte;
               if (pos_inc >= (sfms_pkg::POS_W+1)'(sfms_pkg::SIG_LENGTH)) begin
                  phase_in = (phase_ff == sfms_pkg::PH_START) ?
                             sfms_pkg::PH_PAYLOAD : sfms_pkg::PH_DONE;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_inc[sfms_pkg::POS_W-1:0];
               end
            end else begin
               phase_in = sfms_pkg::PH_START;
               pos_in   = '0;
            end
         end
         sfms_pkg::PH_PAYLOAD: begin
            stage_we   = 1'b1;
            byte_rv    = 1'b1;
            byte_reply = out_rd_ff;
            if (pos_inc >= (sfms_pkg::POS_W+1)'(BUFFER_SIZE)) begin
               phase_in = sfms_pkg::PH_END;
               pos_in   = '0;
            end else begin
               pos_in = pos_inc[sfms_pkg::POS_W-1:0];
            end
         end
         sfms_pkg::PH_DONE: begin
            out_bump = 1'b1;
         end
      endcase
   end

   // Phase and position.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfms_pkg::PH_START;
         pos_ff   <= '0;
      end else if (cmd.byte_commit) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end else if (cmd.finish) begin
         phase_ff <= sfms_pkg::PH_START;
         pos_ff   <= '0;
      end
   end

   // Received byte is held until the request is finished.
   always_ff @(posedge clock) begin
      if (cmd.item_read) begin
         rx_ff <= req_rx_byte;
      end
   end

   // Outgoing store: one write port, one registered read port.
   assign out_raddr = (phase_ff == sfms_pkg::PH_DONE) ? ovr_idx_ff : pos_ff;
   assign out_we    = cmd.out_write || (cmd.byte_commit && out_bump);
   assign out_waddr = cmd.out_write ? req_out_index : ovr_idx_ff;
   assign out_wdata = cmd.out_write ? req_out_value : (out_rd_ff + sfms_pkg::BYTE_W'(1));

   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_waddr] <= out_wdata;
      end
      if (cmd.item_read) begin
         out_rd_ff <= out_vld_ff[out_raddr] ? out_mem[out_raddr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= '0;
      end else if (out_we) begin
         out_vld_ff[out_waddr] <= 1'b1;
      end
   end

   // Staging store: written by payload bytes, read by the poll scan.
   assign stage_waddr = pos_ff[SA_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.byte_commit && stage_we) begin
         stage_mem[stage_waddr] <= rx_ff;
      end
      if (cmd.scan_read) begin
         stage_rd_ff <= stage_vld_ff[scan_addr_ff] ? stage_mem[scan_addr_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else if (cmd.byte_commit && stage_we) begin
         stage_vld_ff[stage_waddr] <= 1'b1;
      end
   end

   // Committed store: read and updated at the scan address.
   always_ff @(posedge clock) begin
      if (cmd.scan_commit) begin
         comm_mem[scan_addr_ff] <= stage_rd_ff;
      end
      if (cmd.scan_read) begin
         comm_rd_ff <= comm_vld_ff[scan_addr_ff] ? comm_mem[scan_addr_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comm_vld_ff <= '0;
      end else if (cmd.scan_commit) begin
         comm_vld_ff[scan_addr_ff] <= 1'b1;
      end
   end

   // Scan address counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_clear) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_commit || cmd.scan_skip) begin
         scan_addr_ff <= scan_addr_ff + SA_W'(1);
      end
   end

   // Output register; it is loaded only when empty or being drained.
   assign rsp_load = cmd.byte_commit || cmd.scan_commit || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_commit) begin
         rsp_kind_ff <= sfms_pkg::KIND_REPLY;
         rsp_last_ff <= 1'b1;
         rsp_rv_ff   <= byte_rv;
         rsp_rb_ff   <= byte_reply;
         rsp_ca_ff   <= '0;
         rsp_ov_ff   <= '0;
         rsp_nv_ff   <= '0;
      end else if (cmd.scan_commit) begin
         rsp_kind_ff <= sfms_pkg::KIND_CHANGE;
         rsp_last_ff <= 1'b0;
         rsp_rv_ff   <= 1'b0;
         rsp_rb_ff   <= '0;
         rsp_ca_ff   <= sfms_pkg::OUT_ADDR_W'(scan_addr_ff);
         rsp_ov_ff   <= comm_rd_ff;
         rsp_nv_ff   <= stage_rd_ff;
      end else if (cmd.finish) begin
         rsp_kind_ff <= sfms_pkg::KIND_DONE;
         rsp_last_ff <= 1'b1;
         rsp_rv_ff   <= 1'b0;
         rsp_rb_ff   <= '0;
         rsp_ca_ff   <= '0;
         rsp_ov_ff   <= '0;
         rsp_nv_ff   <= '0;
      end
   end

   // Status to the controller.
   assign sts.phase     = phase_ff;
   assign sts.scan_diff = (stage_rd_ff != comm_rd_ff);
   assign sts.scan_last = (scan_addr_ff == SA_W'(BUFFER_SIZE - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_tlast       = rsp_last_ff;
   assign rsp_reply_valid = rsp_rv_ff;
   assign rsp_reply_byte  = rsp_rb_ff;
   assign rsp_change_addr = rsp_ca_ff;
   assign rsp_old_value   = rsp_ov_ff;
   assign rsp_new_value   = rsp_nv_ff;

endmodule

// ----- hw/rtl/spi_framed_mailbox_slave_core.sv -----
// Channel   | Direction | Handshake           | Contents
// req_*     | in        | tvalid/tready       | tuser func; tdata rx_byte, out_index, out_value
// rsp_*     | out       | tvalid/tready/tlast | tuser kind; tdata reply and change report
// csr_*     | in        | csr_we              | register index and write data
//
// A byte request is accepted with the outgoing store read, then loads its reply
// once the output is free. A poll that commits reads the staging and committed stores
// for each entry, then compares them, and waits on output stalls for changed entries.
// Store writes and polls that cause no result complete in the idle state that takes them.
// Reset is synchronous; it clears control state and the store valid bits at once.
// A stalled output holds the next request only when that request has a result to load.
module spi_framed_mailbox_slave_core #(
   parameter int BUFFER_SIZE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [23:0] req_tdata,   // [7:0] rx_byte, [12:8] out_index, [20:13] out_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic [31:0] rsp_tdata,   // [0] reply_valid, [8:1] reply_byte, [13:9] change_addr,
                                    // [21:14] old_value, [29:22] new_value
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   sfms_pkg::cmd_type cmd;
   sfms_pkg::sts_type sts;

   logic                            rsp_reply_valid;
   logic [sfms_pkg::BYTE_W-1:0]     rsp_reply_byte;
   logic [sfms_pkg::OUT_ADDR_W-1:0] rsp_change_addr;
   logic [sfms_pkg::BYTE_W-1:0]     rsp_old_value;
   logic [sfms_pkg::BYTE_W-1:0]     rsp_new_value;

   // Sequencing of each request.
   sfms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Stores, frame tracking and the output register.
   sfms_datapath #(
      .BUFFER_SIZE (BUFFER_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_rx_byte     (req_tdata[7:0]),
      .req_out_index   (req_tdata[12:8]),
      .req_out_value   (req_tdata[20:13]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_kind        (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_reply_byte  (rsp_reply_byte),
      .rsp_change_addr (rsp_change_addr),
      .rsp_old_value   (rsp_old_value),
      .rsp_new_value   (rsp_new_value)
   );

   assign rsp_tdata = {2'b00, rsp_new_value, rsp_old_value, rsp_change_addr,
                       rsp_reply_byte, rsp_reply_valid};

`ifndef SYNTHESIS
   // Only one source loads the output register in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.byte_commit, cmd.scan_commit, cmd.finish}))
      else $error("output register loaded from two sources");

   // The output register is never overwritten while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.byte_commit || cmd.scan_commit || cmd.finish) |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // A finished commit rearms the start hunt.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (sts.phase == sfms_pkg::PH_START))
      else $error("commit did not rearm the start hunt");

   // A scan starts only from a completed frame.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_clear |-> (sts.phase == sfms_pkg::PH_DONE))
      else $error("commit scan started without a completed frame");
`endif

endmodule
